/* src/least_loaded_dispatch_rebalancer_top_macros.svh */
// ----------------------------------------------------------------------------
// Dispatch rebalancer assertion macros
// Shared concurrent assertion forms for the dispatcher top level.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_DISPATCH_REBALANCER_TOP_MACROS_SVH
`define LEAST_LOADED_DISPATCH_REBALANCER_TOP_MACROS_SVH
// check an implication on every edge outside reset
`define LLD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// check an implication in the next cycle
`define LLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/lldr_pkg.sv */
// ----------------------------------------------------------------------------
// Dispatch rebalancer package
// Widths, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package lldr_pkg;
  localparam int Workers    = 8;
  localparam int QueueLimit = 1023;
  localparam int IdxW  = $clog2(Workers);
  localparam int CntW  = $clog2(Workers + 1);
  localparam int LoadW = $clog2(QueueLimit + 1);
  localparam int SumW  = LoadW + IdxW + 1;

  localparam logic [1:0] StOwn   = 2'd0;
  localparam logic [1:0] StStole = 2'd1;
  localparam logic [1:0] StNone  = 2'd2;
  localparam logic [1:0] StFull  = 2'd3;

  localparam logic CfgThreshold = 1'b0;
  localparam logic CfgActive    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_APPLY, S_SUM, S_DIV, S_OUTER, S_STEP, S_MOVE, S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic scan_init;
    logic scan_step;
    logic apply;
    logic sum_init;
    logic sum_step;
    logic div_step;
    logic outer_init;
    logic outer_next;
    logic step_init;
    logic step_scan;
    logic move;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rebal_req;
    logic sum_done;
    logic div_done;
    logic outer_done;
    logic outer_skip;
    logic step_more;
    logic step_done;
  } stat_t;
endpackage

/* src/lldr_ctrl.sv */
// ----------------------------------------------------------------------------
// Dispatch rebalancer controller
// Sequences scan, rebalance and result stages over the datapath.
// ----------------------------------------------------------------------------
module lldr_ctrl import lldr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  out_busy_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (stat_i.scan_done) state_d = S_APPLY;
      S_APPLY: state_d = stat_i.rebal_req ? S_SUM : S_OUT;
      S_SUM:   if (stat_i.sum_done) state_d = S_DIV;
      S_DIV:   if (stat_i.div_done) state_d = S_OUTER;
      S_OUTER: begin
        if (stat_i.outer_done) state_d = S_OUT;
        else if (!stat_i.outer_skip && stat_i.step_more) state_d = S_STEP;
      end
      S_STEP:  if (stat_i.step_done) state_d = S_MOVE;
      S_MOVE:  state_d = S_OUTER;
      S_OUT:   if (!out_busy_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.start = in_valid_i;
        cmd_o.scan_init = in_valid_i;
      end
      S_SCAN:  cmd_o.scan_step = 1'b1;
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        cmd_o.sum_init = 1'b1;
      end
      S_SUM:   cmd_o.sum_step = 1'b1;
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.outer_init = stat_i.div_done;
      end
      S_OUTER: begin
        if (!stat_i.outer_done) begin
          if (!stat_i.outer_skip && stat_i.step_more) cmd_o.step_init = 1'b1;
          else cmd_o.outer_next = 1'b1;
        end
      end
      S_STEP:  cmd_o.step_scan = 1'b1;
      S_MOVE: begin
        cmd_o.move = 1'b1;
      end
      S_OUT:   cmd_o.out_load = !out_busy_i;
      default: cmd_o = '0;
    endcase
  end
endmodule

/* src/lldr_datapath.sv */
// ----------------------------------------------------------------------------
// Dispatch rebalancer datapath
// Queue loads, submit counter, scan unit, serial divider, output register.
// ----------------------------------------------------------------------------
module lldr_datapath import lldr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             action_i,
  input  logic [2:0]       worker_i,
  input  logic [2:0]       probe_start_i,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       chosen_worker_o,
  output logic [1:0]       status_o,
  output logic             rebalanced_o,
  output logic [12:0]      tasks_moved_o
);
  logic [LoadW-1:0] load_q [Workers];
  logic [15:0]      subs_q, thr_q;
  logic [3:0]       act_q;
  logic [CntW-1:0]  n;
  logic             act_q_ld, wk_q;
  logic [IdxW-1:0]  wkr_q, probe_q, scan_q, best_q, outer_q;
  logic [CntW-1:0]  cnt_q;
  logic             found_q;
  logic [LoadW-1:0] bestv_q, cur_q, exc_q;
  logic [SumW-1:0]  sum_q, rem_q;
  logic [LoadW-1:0] avg_q;
  logic [SumW-1:0]  trial;
  logic [IdxW-1:0]  vidx;
  logic [CntW:0]    vsum;
  logic [12:0]      moved_q;
  logic [1:0]       status_q;
  logic [IdxW-1:0]  chosen_q;
  logic             rebal_q, ovalid_q;
  logic [15:0]      subs_inc;
  logic [IdxW-1:0]  res_chosen_q;
  logic [1:0]       res_status_q;
  logic             res_rebal_q;
  logic [12:0]      res_moved_q;

  // reduce the probe start into the active range, one bit per step
  function automatic logic [IdxW-1:0] wrap_start(logic [2:0] p, logic [CntW-1:0] d);
    logic [CntW:0] r;
    r = '0;
    for (int b = 2; b >= 0; b--) begin
      r = {r[CntW-1:0], p[b]};
      if (r >= (CntW+1)'(d)) r = r - (CntW+1)'(d);
    end
    return IdxW'(r);
  endfunction

  assign n = (act_q == 4'd0) ? CntW'(1) :
             ({1'b0, act_q} > 5'(Workers)) ? CntW'(Workers) : CntW'(act_q);
  assign vsum = (CntW+1)'(probe_q) + (CntW+1)'(cnt_q);
  assign vidx = (vsum >= (CntW+1)'(n)) ? IdxW'(vsum - (CntW+1)'(n)) : IdxW'(vsum);
  assign trial = {rem_q[SumW-2:0], sum_q[SumW-1]};
  assign subs_inc = (subs_q != 16'hFFFF) ? subs_q + 16'd1 : subs_q;
  assign act_q_ld = 1'b0;

  always_comb begin
    stat_o = '0;
    stat_o.scan_done = (cnt_q == n) || (wk_q && found_q);
    stat_o.rebal_req = !wk_q && (subs_inc > thr_q);
    stat_o.sum_done = (cnt_q == n);
    stat_o.div_done = (cnt_q == CntW'(SumW));
    stat_o.outer_done = ({1'b0, outer_q} >= CntW'(n)) || found_q;
    stat_o.outer_skip = (cur_q <= avg_q);
    stat_o.step_more = (exc_q != '0) && (load_q[outer_q] != '0);
    stat_o.step_done = (cnt_q == n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Workers; i++) load_q[i] <= '0;
      subs_q <= '0;
      thr_q <= 16'd64;
      act_q <= 4'd8;
      ovalid_q <= 1'b0;
      cnt_q <= '0;
      found_q <= 1'b0;
      res_chosen_q <= '0;
      res_status_q <= StNone;
      res_rebal_q <= 1'b0;
      res_moved_q <= '0;
    end else begin
      if (cfg_we_i && !act_q_ld) begin
        if (cfg_idx_i == CfgThreshold) thr_q <= cfg_data_i;
        else act_q <= cfg_data_i[3:0];
      end
      if (cmd_i.scan_init) begin
        cnt_q <= '0;
        found_q <= 1'b0;
        best_q <= '0;
        chosen_q <= '0;
        status_q <= StNone;
        moved_q <= '0;
        rebal_q <= 1'b0;
        wk_q <= action_i;
        wkr_q <= worker_i;
        probe_q <= wrap_start(probe_start_i, n);
      end
      if (cmd_i.scan_step && !stat_o.scan_done) begin
        if (!wk_q) begin
          if (cnt_q == CntW'(0) || load_q[scan_q] < load_q[best_q]) best_q <= scan_q;
          cnt_q <= cnt_q + CntW'(1);
        end else if ({1'b0, wkr_q} >= CntW'(n)) begin
          found_q <= 1'b1;
        end else if (load_q[wkr_q] != '0) begin
          found_q <= 1'b1;
          chosen_q <= wkr_q;
          status_q <= StOwn;
        end else begin
          if (vidx != wkr_q && load_q[vidx] != '0) begin
            found_q <= 1'b1;
            chosen_q <= vidx;
            status_q <= StStole;
          end
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.apply) begin
        found_q <= 1'b0;
        if (wk_q) begin
          if (status_q != StNone) load_q[chosen_q] <= load_q[chosen_q] - LoadW'(1);
        end else begin
          chosen_q <= best_q;
          if (load_q[best_q] >= LoadW'(QueueLimit)) status_q <= StFull;
          else begin
            status_q <= StOwn;
            load_q[best_q] <= load_q[best_q] + LoadW'(1);
          end
          subs_q <= stat_o.rebal_req ? 16'd0 : subs_inc;
          rebal_q <= stat_o.rebal_req;
        end
      end
      if (cmd_i.sum_init) begin
        cnt_q <= '0;
        sum_q <= '0;
      end
      if (cmd_i.sum_step) begin
        if (cnt_q == n) begin
          cnt_q <= '0;
          rem_q <= '0;
        end else begin
          sum_q <= sum_q + SumW'(load_q[IdxW'(cnt_q)]);
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.div_step && !stat_o.div_done) begin
        if (trial >= SumW'(n)) begin
          rem_q <= trial - SumW'(n);
          sum_q <= {sum_q[SumW-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          sum_q <= {sum_q[SumW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.outer_init) begin
        avg_q <= LoadW'(sum_q);
        outer_q <= '0;
        cur_q <= load_q[0];
        exc_q <= (load_q[0] > LoadW'(sum_q)) ? load_q[0] - LoadW'(sum_q) : '0;
      end
      if (cmd_i.outer_next) begin
        if ({1'b0, outer_q} == CntW'(n) - CntW'(1)) found_q <= 1'b1;
        else begin
          outer_q <= outer_q + IdxW'(1);
          cur_q <= load_q[outer_q + IdxW'(1)];
          exc_q <= (load_q[outer_q + IdxW'(1)] > avg_q) ?
                   load_q[outer_q + IdxW'(1)] - avg_q : '0;
        end
      end
      if (cmd_i.step_init) begin
        cnt_q <= '0;
        best_q <= outer_q;
        bestv_q <= cur_q;
      end
      if (cmd_i.step_scan && !stat_o.step_done) begin
        if (IdxW'(cnt_q) != outer_q && load_q[IdxW'(cnt_q)] < bestv_q) begin
          best_q <= IdxW'(cnt_q);
          bestv_q <= load_q[IdxW'(cnt_q)];
        end
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.move) begin
        exc_q <= exc_q - LoadW'(1);
        if (best_q != outer_q) begin
          load_q[outer_q] <= load_q[outer_q] - LoadW'(1);
          load_q[best_q] <= load_q[best_q] + LoadW'(1);
          if (moved_q != 13'h1FFF) moved_q <= moved_q + 13'd1;
        end
      end
      if (cmd_i.out_load) begin
        ovalid_q <= 1'b1;
        res_chosen_q <= chosen_q;
        res_status_q <= status_q;
        res_rebal_q <= rebal_q;
        res_moved_q <= moved_q;
      end else if (ovalid_q && !out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign scan_q = IdxW'(cnt_q);
  assign out_valid_o = ovalid_q;
  assign chosen_worker_o = 3'(res_chosen_q);
  assign status_o = res_status_q;
  assign rebalanced_o = res_rebal_q;
  assign tasks_moved_o = res_moved_q;
endmodule

/* src/least_loaded_dispatch_rebalancer_top.sv */
// Eight active queues: a submit scans every queue, then its result is registered;
// a work request stops at its own queue if it holds work, else scans to steal.
// A rebalance adds a load sum, a serial divide and a least-loaded scan per task step.
// One item in flight; the next beat is taken the cycle after the result is registered.
// Reset clears loads and submit count and sets threshold / active count to 64 / 8 at once.
// ----------------------------------------------------------------------------
// Dispatch rebalancer top level
// Joins the controller and the datapath.
// ----------------------------------------------------------------------------
`include "least_loaded_dispatch_rebalancer_top_macros.svh"
module least_loaded_dispatch_rebalancer_top import lldr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [2:0]  worker_i,
  input  logic [2:0]  probe_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  chosen_worker_o,
  output logic [1:0]  status_o,
  output logic        rebalanced_o,
  output logic [12:0] tasks_moved_o
);
  cmd_t  cmd;
  stat_t stat;

  lldr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i(out_valid_o && out_stall_i), .stat_i(stat), .cmd_o(cmd)
  );

  lldr_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .action_i, .worker_i, .probe_start_i, .cmd_i(cmd), .stat_o(stat),
    .out_valid_o, .out_stall_i, .chosen_worker_o, .status_o,
    .rebalanced_o, .tasks_moved_o
  );

  `LLD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(chosen_worker_o) && $stable(status_o) &&
    $stable(rebalanced_o) && $stable(tasks_moved_o), "result changed while stalled")
  `LLD_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o, "no stall after accept")
  `LLD_ASSERT_IMP(a_work_norebal, out_valid_o && status_o == StStole, !rebalanced_o,
    "rebalance on steal")
endmodule
